// File: rtl/core/vector_command_speed_limiter_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the speed limiter core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef VECTOR_COMMAND_SPEED_LIMITER_CORE_ASSERT_SVH
`define VECTOR_COMMAND_SPEED_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication.
`define VCSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VCSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/vcsl_pkg.sv
// ----------------------------------------------------------------------------
// vcsl_pkg
// Widths, payload structs and pipeline records of the speed limiter.
// ----------------------------------------------------------------------------
package vcsl_pkg;

    localparam int CMD_W      = 16;
    localparam int SPD_W      = 16;
    localparam int SCALE_W    = 24;
    localparam int FRAC_SHIFT = 16;               // radicand shift, 8 root fraction bits
    localparam int QSHIFT     = 24;               // fraction bits of the speed product
    localparam int RT_W       = CMD_W + 8;
    localparam int RAD_W      = 2 * RT_W;
    localparam int REM_W      = RT_W + 4;
    localparam int P_W        = RT_W + SCALE_W;
    localparam int N_W        = CMD_W + SPD_W;
    localparam int DV_W       = P_W + CMD_W;
    localparam int SQ_STEPS   = 4;
    localparam int SQ_STAGES  = RT_W / SQ_STEPS;
    localparam int DV_STEPS   = 2;
    localparam int DV_STAGES  = CMD_W / DV_STEPS;

    typedef struct packed {
        logic signed [CMD_W-1:0] vel_x_in;
        logic signed [CMD_W-1:0] vel_y_in;
        logic        [SPD_W-1:0] allowed_speed;
    } vcsl_cmd_t;

    typedef struct packed {
        logic signed [CMD_W-1:0] vel_x_out;
        logic signed [CMD_W-1:0] vel_y_out;
        logic                    was_limited;
    } vcsl_res_t;

    typedef struct packed {
        logic [CMD_W-1:0] vx;
        logic [CMD_W-1:0] vy;
        logic [SPD_W-1:0] allowed;
    } vcsl_side_t;

    typedef struct packed {
        vcsl_side_t       side;
        logic [CMD_W-1:0] ax;
        logic [CMD_W-1:0] ay;
        logic [RAD_W-1:0] rad;
        logic [RT_W-1:0]  root;
        logic [REM_W-1:0] rem;
    } vcsl_sq_t;

    typedef struct packed {
        vcsl_side_t       side;
        logic [P_W-1:0]   p;
        logic [DV_W-1:0]  rx;
        logic [DV_W-1:0]  ry;
        logic [CMD_W-1:0] qx;
        logic [CMD_W-1:0] qy;
    } vcsl_dv_t;

endpackage

// File: rtl/core/vcsl_sqrt_stage.sv
// ----------------------------------------------------------------------------
// vcsl_sqrt_stage
// One register stage of the digit-by-digit square root, SQ_STEPS digits.
// ----------------------------------------------------------------------------
module vcsl_sqrt_stage
    import vcsl_pkg::*;
#(
    parameter int FIRST = 23
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     up_valid,
    input  vcsl_sq_t up_data,
    output logic     dn_valid,
    output vcsl_sq_t dn_data
);

    logic     dn_valid_reg;
    vcsl_sq_t dn_data_reg;
    vcsl_sq_t dn_data_next;

    always_comb
    begin
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        dn_data_next = up_data;
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            rem_sh = {dn_data_next.rem[REM_W-3:0], dn_data_next.rad[2*(FIRST-j) +: 2]};
            trial  = REM_W'({dn_data_next.root, 2'b01});
            if (rem_sh >= trial)
            begin
                dn_data_next.rem  = rem_sh - trial;
                dn_data_next.root = {dn_data_next.root[RT_W-2:0], 1'b1};
            end
            else
            begin
                dn_data_next.rem  = rem_sh;
                dn_data_next.root = {dn_data_next.root[RT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_valid_reg <= 1'b0;
        else if (en)
            dn_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dn_data_reg <= dn_data_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

endmodule

// File: rtl/core/vcsl_div_stage.sv
// ----------------------------------------------------------------------------
// vcsl_div_stage
// One register stage of the two-lane restoring divider, DV_STEPS bits.
// ----------------------------------------------------------------------------
module vcsl_div_stage
    import vcsl_pkg::*;
#(
    parameter int FIRST = 15
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     en,
    input  logic     up_valid,
    input  vcsl_dv_t up_data,
    output logic     dn_valid,
    output vcsl_dv_t dn_data
);

    logic     dn_valid_reg;
    vcsl_dv_t dn_data_reg;
    vcsl_dv_t dn_data_next;

    always_comb
    begin
        logic [DV_W-1:0] dsh;
        dn_data_next = up_data;
        for (int j = 0; j < DV_STEPS; j++)
        begin
            dsh = DV_W'(dn_data_next.p) << (FIRST - j);
            if (dn_data_next.rx >= dsh)
            begin
                dn_data_next.rx             = dn_data_next.rx - dsh;
                dn_data_next.qx[FIRST - j]  = 1'b1;
            end
            if (dn_data_next.ry >= dsh)
            begin
                dn_data_next.ry             = dn_data_next.ry - dsh;
                dn_data_next.qy[FIRST - j]  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_valid_reg <= 1'b0;
        else if (en)
            dn_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dn_data_reg <= dn_data_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn_data  = dn_data_reg;

endmodule

// File: rtl/core/vector_command_speed_limiter_core.sv
// ----------------------------------------------------------------------------
// vector_command_speed_limiter_core
// Limits the Euclidean speed of a two-axis velocity command pair.
// ----------------------------------------------------------------------------
// Stages: capture, squares, root seed, root stages, product, divider, output.
// Throughput: one transaction per cycle; the whole pipeline advances together,
//   so a stalled result holds every stage and the command side stalls.
// Per-cycle work is set by four root digits per square-root stage and two
//   quotient bits per divider stage.
// Reset: rst_n clears all valid bits and sets scale_reg to zero.
module vector_command_speed_limiter_core
    import vcsl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [SCALE_W-1:0] cfg_wdata,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  vcsl_cmd_t          cmd,
    output logic               res_valid,
    input  logic               res_stall,
    output vcsl_res_t          res
);

    // Global advance: every stage moves unless a finished result is stalled.
    logic en;

    logic [SCALE_W-1:0] scale_reg;

    // Stage 0: capture and absolute values.
    logic             v0_reg;
    vcsl_side_t       side0_reg;
    logic [CMD_W-1:0] ax0_reg, ay0_reg;
    logic [CMD_W-1:0] ax0_next, ay0_next;

    // Stage 1: squares.
    logic               v1_reg;
    vcsl_side_t         side1_reg;
    logic [CMD_W-1:0]   ax1_reg, ay1_reg;
    logic [2*CMD_W-1:0] sqx1_reg, sqy1_reg;

    // Stage 2: sum of squares, square-root seed.
    logic               v2_reg;
    vcsl_sq_t           sq2_reg;
    vcsl_sq_t           sq2_next;
    logic [2*CMD_W-1:0] ssum;

    logic     sq_v [0:SQ_STAGES];
    vcsl_sq_t sq_d [0:SQ_STAGES];

    // Stage 3: speed product and dividends.
    logic           v3_reg;
    vcsl_side_t     side3_reg;
    logic [P_W-1:0] p3_reg;
    logic [N_W-1:0] nx3_reg, ny3_reg;

    logic     dv_v [0:DV_STAGES];
    vcsl_dv_t dv_d [0:DV_STAGES];
    vcsl_dv_t dv0_next;

    // Output register.
    logic      res_valid_reg;
    vcsl_res_t res_reg;
    vcsl_res_t res_next;

    assign en        = !(res_valid_reg && res_stall);
    assign cmd_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            scale_reg <= '0;
        else if (cfg_we)
            scale_reg <= cfg_wdata;
    end

    // Most negative value maps to its exact unsigned magnitude.
    always_comb
    begin
        ax0_next = cmd.vel_x_in[CMD_W-1] ? (~cmd.vel_x_in + 1'b1) : cmd.vel_x_in;
        ay0_next = cmd.vel_y_in[CMD_W-1] ? (~cmd.vel_y_in + 1'b1) : cmd.vel_y_in;
    end

    always_comb
    begin
        ssum           = sqx1_reg + sqy1_reg;
        sq2_next.side  = side1_reg;
        sq2_next.ax    = ax1_reg;
        sq2_next.ay    = ay1_reg;
        sq2_next.rad   = RAD_W'({ssum, {FRAC_SHIFT{1'b0}}});
        sq2_next.root  = '0;
        sq2_next.rem   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= cmd_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= sq_v[SQ_STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side0_reg.vx      <= cmd.vel_x_in;
            side0_reg.vy      <= cmd.vel_y_in;
            side0_reg.allowed <= cmd.allowed_speed;
            ax0_reg           <= ax0_next;
            ay0_reg           <= ay0_next;

            side1_reg <= side0_reg;
            ax1_reg   <= ax0_reg;
            ay1_reg   <= ay0_reg;
            sqx1_reg  <= (2*CMD_W)'(ax0_reg) * (2*CMD_W)'(ax0_reg);
            sqy1_reg  <= (2*CMD_W)'(ay0_reg) * (2*CMD_W)'(ay0_reg);

            sq2_reg <= sq2_next;

            side3_reg <= sq_d[SQ_STAGES].side;
            p3_reg    <= P_W'(sq_d[SQ_STAGES].root) * P_W'(scale_reg);
            nx3_reg   <= N_W'(sq_d[SQ_STAGES].ax) * N_W'(sq_d[SQ_STAGES].side.allowed);
            ny3_reg   <= N_W'(sq_d[SQ_STAGES].ay) * N_W'(sq_d[SQ_STAGES].side.allowed);
        end
    end

    // Square root: root has 8 fraction bits, top digit first.
    assign sq_v[0] = v2_reg;
    assign sq_d[0] = sq2_reg;

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_sqrt
        vcsl_sqrt_stage #(
            .FIRST (RT_W - 1 - SQ_STEPS * g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (sq_v[g]),
            .up_data  (sq_d[g]),
            .dn_valid (sq_v[g+1]),
            .dn_data  (sq_d[g+1])
        );
    end

    // Divider seed: dividend is |v| * allowed * 2^24, divisor the speed product.
    // In a limited result the quotient stays below |v|, so CMD_W quotient bits suffice.
    assign dv_v[0] = v3_reg;
    assign dv_d[0] = dv0_next;

    always_comb
    begin
        dv0_next.side = side3_reg;
        dv0_next.p    = p3_reg;
        dv0_next.rx   = DV_W'({nx3_reg, {QSHIFT{1'b0}}});
        dv0_next.ry   = DV_W'({ny3_reg, {QSHIFT{1'b0}}});
        dv0_next.qx   = '0;
        dv0_next.qy   = '0;
    end

    for (genvar g = 0; g < DV_STAGES; g++)
    begin : g_div
        vcsl_div_stage #(
            .FIRST (CMD_W - 1 - DV_STEPS * g)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (dv_v[g]),
            .up_data  (dv_d[g]),
            .dn_valid (dv_v[g+1]),
            .dn_data  (dv_d[g+1])
        );
    end

    // Final select. A zero product means zero scale or a zero pair: pass through.
    // Limit when allowed is zero or allowed * 2^24 is below the product.
    always_comb
    begin
        vcsl_dv_t d;
        logic     lim;
        d   = dv_d[DV_STAGES];
        lim = (d.p != '0) &&
              ((d.side.allowed == '0) ||
               (P_W'({d.side.allowed, {QSHIFT{1'b0}}}) < d.p));
        res_next.vel_x_out   = d.side.vx;
        res_next.vel_y_out   = d.side.vy;
        res_next.was_limited = lim;
        if (lim)
        begin
            if (d.side.allowed == '0)
            begin
                res_next.vel_x_out = '0;
                res_next.vel_y_out = '0;
            end
            else
            begin
                res_next.vel_x_out = d.side.vx[CMD_W-1] ? (~d.qx + 1'b1) : d.qx;
                res_next.vel_y_out = d.side.vy[CMD_W-1] ? (~d.qy + 1'b1) : d.qy;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (en)
            res_valid_reg <= dv_v[DV_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            res_reg <= res_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`include "vector_command_speed_limiter_core_assert.svh"

    // The command side stalls only behind a stalled result.
    `VCSL_ASSERT_NOW(a_stall_cause, cmd_stall, res_valid && res_stall, "command stall without held result")
    // A frozen pipeline keeps the divider's last stage intact.
    `VCSL_ASSERT_NEXT(a_div_hold, !en, $stable(dv_d[DV_STAGES]) && $stable(dv_v[DV_STAGES]), "divider output moved while frozen")
    // A frozen pipeline keeps the square-root output intact.
    `VCSL_ASSERT_NEXT(a_sqrt_hold, !en, $stable(sq_d[SQ_STAGES]), "root output moved while frozen")

endmodule
